[src/mtpp_pkg.sv]
package mtpp_pkg;

    localparam int LVL_W    = 3;
    localparam int TICK_W   = 32;
    localparam int WAIT_W   = 16;
    localparam int PIDX_W   = 6;
    localparam int MASK_W   = 64;
    localparam int CNT_W    = 7;

    localparam logic [WAIT_W-1:0] WAIT_LIMIT_RESET = 16'd30;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_SLICE  = 2'd1,
        CAUSE_BETTER = 2'd2
    } cause_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic              promote;
        logic              compete;
        logic [LVL_W-1:0]  lvl;
        logic [TICK_W-1:0] stamp;
    } age_res_t;

endpackage

[src/mtpp_tick_if.sv]
interface mtpp_tick_if import mtpp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              running_valid;
    logic [PIDX_W-1:0] running_index;
    logic [MASK_W-1:0] runnable_mask;

    modport source (
        output valid,
        output running_valid,
        output running_index,
        output runnable_mask,
        input  ready
    );

    modport sink (
        input  valid,
        input  running_valid,
        input  running_index,
        input  runnable_mask,
        output ready
    );

endinterface

[src/mtpp_result_if.sv]
interface mtpp_result_if import mtpp_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             preempt;
    logic [1:0]       preempt_cause;
    logic [LVL_W-1:0] running_level;
    logic [CNT_W-1:0] promoted_count;

    modport source (
        output valid,
        output preempt,
        output preempt_cause,
        output running_level,
        output promoted_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  preempt,
        input  preempt_cause,
        input  running_level,
        input  promoted_count,
        output ready
    );

endinterface

[src/mtpp_cell.sv]
module mtpp_cell import mtpp_pkg::*; #(
    parameter int SLC_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [LVL_W-1:0]  shift_lvl,
    input  logic [TICK_W-1:0] shift_stamp,
    input  logic [SLC_W-1:0]  shift_slc,
    input  logic [LVL_W-1:0]  load_lvl,
    input  logic [TICK_W-1:0] load_stamp,
    input  logic [SLC_W-1:0]  load_slc,
    output logic [LVL_W-1:0]  lvl,
    output logic [TICK_W-1:0] stamp,
    output logic [SLC_W-1:0]  slc
);

    logic [LVL_W-1:0]  lvl_reg,   lvl_next;
    logic [TICK_W-1:0] stamp_reg, stamp_next;
    logic [SLC_W-1:0]  slc_reg,   slc_next;

    always_comb
    begin
        priority if (ctl.load)
        begin
            lvl_next   = load_lvl;
            stamp_next = load_stamp;
            slc_next   = load_slc;
        end
        else if (ctl.shift)
        begin
            lvl_next   = shift_lvl;
            stamp_next = shift_stamp;
            slc_next   = shift_slc;
        end
        else
        begin
            lvl_next   = lvl_reg;
            stamp_next = stamp_reg;
            slc_next   = slc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg   <= '0;
            stamp_reg <= '0;
            slc_reg   <= '0;
        end
        else
        begin
            lvl_reg   <= lvl_next;
            stamp_reg <= stamp_next;
            slc_reg   <= slc_next;
        end
    end

    assign lvl   = lvl_reg;
    assign stamp = stamp_reg;
    assign slc   = slc_reg;

endmodule

[src/mtpp_age_unit.sv]
module mtpp_age_unit import mtpp_pkg::*; (
    input  logic [TICK_W-1:0] tick,
    input  logic [WAIT_W-1:0] wait_limit,
    input  logic [LVL_W-1:0]  head_lvl,
    input  logic [TICK_W-1:0] head_stamp,
    input  logic              runnable,
    input  logic              is_run,
    output age_res_t          res
);

    logic [TICK_W-1:0] waited;
    logic              too_old;

    always_comb
    begin
        waited      = tick - head_stamp;
        too_old     = waited > {{(TICK_W-WAIT_W){1'b0}}, wait_limit};
        res.compete = runnable && !is_run;
        res.promote = res.compete && too_old && (head_lvl != '0);
        res.lvl     = res.promote ? head_lvl - LVL_W'(1) : head_lvl;
        res.stamp   = res.promote ? tick : head_stamp;
    end

endmodule

[src/mlfq_tick_preemption_policy_core.sv]
// Tick-driven preemption policy of a multilevel feedback queue scheduler.
// Channels: tick (sink) carries one timer tick per transfer with the running
// process and the runnable mask; result (source) returns one result per tick.
// wait_limit is written through wait_limit_we / wait_limit_data; the user
// must write it only while idle; the block itself leaves this unchecked.
// Per-process level, stamp and slice live in a ring of cells that rotates by
// one entry per cycle past a single aging unit at its head. A tick with a
// running process passes through an accept cycle, a full rotation of the
// ring and a finish cycle that writes back the running entry before the
// next tick is accepted. A tick with no running process goes from the accept
// cycle straight to the finish cycle. The result is valid from the cycle
// after the finish cycle. A finished result sits in an output register; a
// new tick is accepted while it waits. If the receiver stalls, the next
// finish cycle holds until the output register is free.
// Reset clears all process state, the tick counter and result.valid, sets
// wait_limit to 30. tick is ready in the first cycle after reset.
module mlfq_tick_preemption_policy_core import mtpp_pkg::*; #(
    parameter int NUM_PROCS  = 64,
    parameter int NUM_LEVELS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wait_limit_we,
    input  logic [WAIT_W-1:0] wait_limit_data,
    mtpp_tick_if.sink         tick,
    mtpp_result_if.source     result
);

    localparam int IDX_W = $clog2(NUM_PROCS);
    localparam int SLC_W = NUM_LEVELS;
    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(NUM_LEVELS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [TICK_W-1:0]    tick_reg,       tick_next;
    logic [WAIT_W-1:0]    wait_limit_reg, wait_limit_next;
    logic                 run_en_reg,     run_en_next;
    logic [IDX_W-1:0]     run_idx_reg,    run_idx_next;
    logic [NUM_PROCS-1:0] mask_reg,       mask_next;
    logic [IDX_W-1:0]     scan_cnt_reg,   scan_cnt_next;
    logic [LVL_W-1:0]     min_lvl_reg,    min_lvl_next;
    logic [LVL_W-1:0]     run_lvl_reg,    run_lvl_next;
    logic [SLC_W-1:0]     run_slc_reg,    run_slc_next;
    logic [CNT_W-1:0]     prom_cnt_reg,   prom_cnt_next;

    logic                 out_valid_reg,   out_valid_next;
    logic                 out_preempt_reg, out_preempt_next;
    cause_t               out_cause_reg,   out_cause_next;
    logic [LVL_W-1:0]     out_lvl_reg,     out_lvl_next;
    logic [CNT_W-1:0]     out_cnt_reg,     out_cnt_next;

    logic [LVL_W-1:0]  cell_lvl   [NUM_PROCS];
    logic [TICK_W-1:0] cell_stamp [NUM_PROCS];
    logic [SLC_W-1:0]  cell_slc   [NUM_PROCS];

    logic       accept;
    logic       run_ok;
    logic       is_run;
    logic       scan_done;
    logic       out_free;
    logic       fin_fire;
    age_res_t   age;

    logic [SLC_W-1:0] quantum;
    logic             expired;
    logic             better;
    logic [LVL_W-1:0] fin_lvl;
    logic [SLC_W-1:0] fin_slc;
    cause_t           fin_cause;

    assign tick.ready = (state_reg == S_IDLE);
    assign accept     = tick.valid && tick.ready;
    assign run_ok     = tick.running_valid &&
                        ({1'b0, tick.running_index} < (PIDX_W + 1)'(NUM_PROCS));
    assign is_run     = (scan_cnt_reg == run_idx_reg);
    assign scan_done  = (scan_cnt_reg == IDX_W'(NUM_PROCS - 1));
    assign out_free   = !out_valid_reg || result.ready;
    assign fin_fire   = (state_reg == S_FIN) && out_free;

    mtpp_age_unit u_age (
        .tick       (tick_reg),
        .wait_limit (wait_limit_reg),
        .head_lvl   (cell_lvl[0]),
        .head_stamp (cell_stamp[0]),
        .runnable   (mask_reg[0]),
        .is_run     (is_run),
        .res        (age)
    );

    for (genvar k = 0; k < NUM_PROCS; k++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [LVL_W-1:0]  in_lvl;
        logic [TICK_W-1:0] in_stamp;
        logic [SLC_W-1:0]  in_slc;

        if (k == NUM_PROCS - 1)
        begin : g_tail
            assign in_lvl   = age.lvl;
            assign in_stamp = age.stamp;
            assign in_slc   = cell_slc[0];
        end
        else
        begin : g_body
            assign in_lvl   = cell_lvl[k+1];
            assign in_stamp = cell_stamp[k+1];
            assign in_slc   = cell_slc[k+1];
        end

        assign ctl.shift = (state_reg == S_SCAN);
        assign ctl.load  = fin_fire && run_en_reg && (run_idx_reg == IDX_W'(k));

        mtpp_cell #(
            .SLC_W (SLC_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .shift_lvl   (in_lvl),
            .shift_stamp (in_stamp),
            .shift_slc   (in_slc),
            .load_lvl    (fin_lvl),
            .load_stamp  (tick_reg),
            .load_slc    (fin_slc),
            .lvl         (cell_lvl[k]),
            .stamp       (cell_stamp[k]),
            .slc         (cell_slc[k])
        );
    end

    always_comb
    begin
        quantum = SLC_W'(1) << run_lvl_reg;
        expired = run_slc_reg >= quantum;
        better  = min_lvl_reg < run_lvl_reg;
        fin_lvl = (expired && (run_lvl_reg < LAST_LEVEL)) ? run_lvl_reg + LVL_W'(1)
                                                          : run_lvl_reg;
        fin_slc = (expired || better) ? '0 : run_slc_reg;
        priority if (expired)
            fin_cause = CAUSE_SLICE;
        else if (better)
            fin_cause = CAUSE_BETTER;
        else
            fin_cause = CAUSE_NONE;
    end

    always_comb
    begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        wait_limit_next  = wait_limit_we ? wait_limit_data : wait_limit_reg;
        run_en_next      = run_en_reg;
        run_idx_next     = run_idx_reg;
        mask_next        = mask_reg;
        scan_cnt_next    = scan_cnt_reg;
        min_lvl_next     = min_lvl_reg;
        run_lvl_next     = run_lvl_reg;
        run_slc_next     = run_slc_reg;
        prom_cnt_next    = prom_cnt_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_preempt_next = out_preempt_reg;
        out_cause_next   = out_cause_reg;
        out_lvl_next     = out_lvl_reg;
        out_cnt_next     = out_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tick_next     = tick_reg + TICK_W'(1);
                    run_en_next   = run_ok;
                    run_idx_next  = tick.running_index[IDX_W-1:0];
                    mask_next     = tick.runnable_mask[NUM_PROCS-1:0];
                    scan_cnt_next = '0;
                    min_lvl_next  = '1;
                    prom_cnt_next = '0;
                    state_next    = run_ok ? S_SCAN : S_FIN;
                end
            end
            S_SCAN:
            begin
                mask_next     = mask_reg >> 1;
                scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                if (age.promote)
                    prom_cnt_next = prom_cnt_reg + CNT_W'(1);
                if (age.compete && (age.lvl < min_lvl_reg))
                    min_lvl_next = age.lvl;
                if (is_run)
                begin
                    run_lvl_next = cell_lvl[0];
                    run_slc_next = cell_slc[0] + SLC_W'(1);
                end
                if (scan_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (run_en_reg)
                    begin
                        out_preempt_next = (fin_cause != CAUSE_NONE);
                        out_cause_next   = fin_cause;
                        out_lvl_next     = fin_lvl;
                        out_cnt_next     = prom_cnt_reg;
                    end
                    else
                    begin
                        out_preempt_next = 1'b0;
                        out_cause_next   = CAUSE_NONE;
                        out_lvl_next     = '0;
                        out_cnt_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            wait_limit_reg <= WAIT_LIMIT_RESET;
            run_en_reg     <= 1'b0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            wait_limit_reg <= wait_limit_next;
            run_en_reg     <= run_en_next;
            scan_cnt_reg   <= scan_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_idx_reg     <= run_idx_next;
        mask_reg        <= mask_next;
        min_lvl_reg     <= min_lvl_next;
        run_lvl_reg     <= run_lvl_next;
        run_slc_reg     <= run_slc_next;
        prom_cnt_reg    <= prom_cnt_next;
        out_preempt_reg <= out_preempt_next;
        out_cause_reg   <= out_cause_next;
        out_lvl_reg     <= out_lvl_next;
        out_cnt_reg     <= out_cnt_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.preempt        = out_preempt_reg;
    assign result.preempt_cause  = out_cause_reg;
    assign result.running_level  = out_lvl_reg;
    assign result.promoted_count = out_cnt_reg;

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> !tick.ready)
        else $error("tick accepted twice in a row");

    a_preempt_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.preempt == (result.preempt_cause != CAUSE_NONE)))
        else $error("preempt flag disagrees with cause");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.running_level <= LAST_LEVEL))
        else $error("running level beyond last level");

    a_promoted_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.promoted_count < CNT_W'(NUM_PROCS)))
        else $error("promoted count exceeds other processes");

endmodule
